FILE: hw/rtl/soef_pkg.sv
// package for the serialized object end finder
// phase encoding, field type codes, payload widths and length prefix constants
// no dependencies
package soef_pkg;

	// position counter width, saturates at all ones
	localparam int unsigned POS_BITS = 24;
	localparam int unsigned OFS_BITS = 24;
	localparam int unsigned SKIP_BITS = 20;

	typedef enum logic [11:0] {
		PH_HDR   = 12'b0000_0000_0001,
		PH_TYPE  = 12'b0000_0000_0010,
		PH_FIELD = 12'b0000_0000_0100,
		PH_T3    = 12'b0000_0000_1000,
		PH_F3    = 12'b0000_0001_0000,
		PH_SKIP  = 12'b0000_0010_0000,
		PH_AMT   = 12'b0000_0100_0000,
		PH_VL0   = 12'b0000_1000_0000,
		PH_VL1   = 12'b0001_0000_0000,
		PH_VL2A  = 12'b0010_0000_0000,
		PH_VL2B  = 12'b0100_0000_0000,
		PH_PATH  = 12'b1000_0000_0000
	} phase_t;

	// field type codes
	localparam logic [7:0] TY_U16     = 8'd1;
	localparam logic [7:0] TY_U32     = 8'd2;
	localparam logic [7:0] TY_U64     = 8'd3;
	localparam logic [7:0] TY_H128    = 8'd4;
	localparam logic [7:0] TY_H256    = 8'd5;
	localparam logic [7:0] TY_AMOUNT  = 8'd6;
	localparam logic [7:0] TY_BLOB    = 8'd7;
	localparam logic [7:0] TY_ACCOUNT = 8'd8;
	localparam logic [7:0] TY_OBJECT  = 8'd14;
	localparam logic [7:0] TY_ARRAY   = 8'd15;
	localparam logic [7:0] TY_U8      = 8'd16;
	localparam logic [7:0] TY_H160    = 8'd17;
	localparam logic [7:0] TY_PATHSET = 8'd18;
	localparam logic [7:0] TY_VECTOR  = 8'd19;
	localparam logic [7:0] FC_END     = 8'd1;

	// amount: first byte already consumed
	localparam logic [SKIP_BITS-1:0] AMT_LONG  = SKIP_BITS'(47);
	localparam logic [SKIP_BITS-1:0] AMT_SHORT = SKIP_BITS'(7);

	// length prefix ranges
	localparam logic [7:0] VL_ONE_MAX = 8'd192;
	localparam logic [7:0] VL_TWO_MAX = 8'd240;
	localparam logic [7:0] VL_TWO_BASE = 8'd193;
	localparam logic [7:0] VL_THREE_BASE = 8'd241;
	localparam logic [SKIP_BITS-1:0] VL_THREE_OFS = SKIP_BITS'(12481);

	typedef struct packed {
		logic                 hit;
		phase_t               ph;
		logic [SKIP_BITS-1:0] skip;
	} hdr_res_t;

endpackage

FILE: hw/rtl/serialized_object_end_finder.sv
// serialized object end finder: walks field headers and payloads byte by byte
// and reports the offset past the first object or array end marker, or, with found low, the length at is_last
// depends on soef_pkg
//
//  channel  | signals                               | role
//  ---------+---------------------------------------+-------------------------
//  in       | in_valid in_ready byte_in is_last     | one object byte per transfer
//  out      | out_valid out_ready end_offset found  | one result per object
//
// one byte is taken every cycle while in_ready is high; the per-byte decode sits between the phase
// registers and a two-entry output buffer (output register plus skid stage)
// a result is registered into the output register, or into the skid stage while the output is stalled
// in_ready drops only while the skid stage holds a result
// arst_n clears the walker state and empties the output buffer
module serialized_object_end_finder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    byte_in,
	input  logic                          is_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [soef_pkg::OFS_BITS-1:0] end_offset,
	output logic                          found
);
	import soef_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	phase_t                ph_q, ph_d;
	logic [POS_BITS-1:0]   cnt_q, cnt_d;
	logic [SKIP_BITS-1:0]  skip_q, skip_d;
	logic [7:0]            type_q, type_d;
	logic [7:0]            field_q, field_d;
	logic [15:0]           lp_q, lp_d;
	logic                  done_q, done_d;

	logic                  res_valid;
	logic                  res_found;
	logic [OFS_BITS-1:0]   res_ofs;

	logic                  out_valid_q;
	logic [OFS_BITS-1:0]   out_ofs_q;
	logic                  out_found_q;
	logic                  skid_valid_q;
	logic [OFS_BITS-1:0]   skid_ofs_q;
	logic                  skid_found_q;

	logic                  take;
	logic                  hit;
	hdr_res_t              hr;
	logic [7:0]            hdr_t, hdr_f;
	logic                  hdr_eval;

	function automatic hdr_res_t start_skip(input logic [SKIP_BITS-1:0] n);
		hdr_res_t r;
		r.hit  = 1'b0;
		r.skip = n;
		r.ph   = (n != '0) ? PH_SKIP : PH_HDR;
		return r;
	endfunction

	function automatic hdr_res_t hdr_next(input logic [7:0] t, input logic [7:0] f);
		hdr_res_t r;
		r = start_skip('0);
		if ((t == TY_OBJECT || t == TY_ARRAY) && f == FC_END) begin
			r.hit = 1'b1;
		end else begin
			case (t)
				TY_U16:     r = start_skip(SKIP_BITS'(2));
				TY_U32:     r = start_skip(SKIP_BITS'(4));
				TY_U64:     r = start_skip(SKIP_BITS'(8));
				TY_H128:    r = start_skip(SKIP_BITS'(16));
				TY_H256:    r = start_skip(SKIP_BITS'(32));
				TY_ACCOUNT: r = start_skip(SKIP_BITS'(21));
				TY_U8:      r = start_skip(SKIP_BITS'(1));
				TY_H160:    r = start_skip(SKIP_BITS'(20));
				TY_AMOUNT:  r.ph = PH_AMT;
				TY_BLOB, TY_VECTOR: r.ph = PH_VL0;
				TY_PATHSET: r.ph = PH_PATH;
				default:    r.ph = PH_HDR;
			endcase
		end
		return r;
	endfunction

	assign in_ready = !skid_valid_q;
	assign take     = in_valid && in_ready;

	// header byte sources: the type and field codes as they stand after this byte
	always_comb begin
		hdr_t    = type_q;
		hdr_f    = field_q;
		hdr_eval = 1'b0;
		case (ph_q)
			PH_HDR: begin
				hdr_t    = {4'd0, byte_in[7:4]};
				hdr_f    = {4'd0, byte_in[3:0]};
				hdr_eval = (byte_in[7:4] != 4'd0) && (byte_in[3:0] != 4'd0);
			end
			PH_TYPE: begin
				hdr_t    = byte_in;
				hdr_eval = 1'b1;
			end
			PH_FIELD, PH_F3: begin
				hdr_f    = byte_in;
				hdr_eval = 1'b1;
			end
			default: ;
		endcase
	end

	assign hr = hdr_next(hdr_t, hdr_f);

	always_comb begin
		ph_d      = ph_q;
		cnt_d     = cnt_q;
		skip_d    = skip_q;
		type_d    = type_q;
		field_d   = field_q;
		lp_d      = lp_q;
		done_d    = done_q;
		hit       = 1'b0;
		res_valid = 1'b0;
		res_found = 1'b0;
		res_ofs   = OFS_BITS'(cnt_q);
		if (take && !done_q) begin
			if (cnt_q != POS_MAX)
				cnt_d = cnt_q + POS_BITS'(1);
			case (ph_q)
				PH_HDR: begin
					if (byte_in == 8'd0) begin
						ph_d = PH_T3;
					end else if (byte_in[7:4] == 4'd0) begin
						field_d = hdr_f;
						ph_d    = PH_TYPE;
					end else if (byte_in[3:0] == 4'd0) begin
						type_d = hdr_t;
						ph_d   = PH_FIELD;
					end else begin
						type_d  = hdr_t;
						field_d = hdr_f;
					end
				end
				PH_TYPE:         type_d = byte_in;
				PH_FIELD, PH_F3: field_d = byte_in;
				PH_T3: begin
					type_d = byte_in;
					ph_d   = PH_F3;
				end
				PH_SKIP: begin
					if (skip_q <= SKIP_BITS'(1)) begin
						skip_d = '0;
						ph_d   = PH_HDR;
					end else begin
						skip_d = skip_q - SKIP_BITS'(1);
					end
				end
				PH_AMT: begin
					skip_d = byte_in[7] ? AMT_LONG : AMT_SHORT;
					ph_d   = PH_SKIP;
				end
				PH_VL0: begin
					if (byte_in <= VL_ONE_MAX) begin
						skip_d = SKIP_BITS'(byte_in);
						ph_d   = (byte_in != 8'd0) ? PH_SKIP : PH_HDR;
					end else begin
						lp_d = {8'd0, byte_in};
						ph_d = (byte_in <= VL_TWO_MAX) ? PH_VL1 : PH_VL2A;
					end
				end
				PH_VL1: begin
					// two-byte prefix never yields zero
					skip_d = SKIP_BITS'({lp_q[5:0] - VL_TWO_BASE[5:0], byte_in})
						+ SKIP_BITS'(VL_TWO_BASE);
					ph_d   = PH_SKIP;
				end
				PH_VL2A: begin
					lp_d = {lp_q[7:0], byte_in};
					ph_d = PH_VL2B;
				end
				PH_VL2B: begin
					skip_d = SKIP_BITS'({lp_q[11:8] - VL_THREE_BASE[3:0], lp_q[7:0], byte_in})
						+ VL_THREE_OFS;
					ph_d   = PH_SKIP;
				end
				PH_PATH: begin
					if (byte_in == 8'h00)
						ph_d = PH_HDR;
				end
				default: ph_d = PH_HDR;
			endcase
			if (hdr_eval) begin
				hit = hr.hit;
				if (!hr.hit) begin
					ph_d   = hr.ph;
					skip_d = hr.skip;
				end
			end
			if (hit || is_last) begin
				res_valid = 1'b1;
				res_found = hit;
				res_ofs   = OFS_BITS'(cnt_d);
				done_d    = !is_last;
			end
		end
		if (take && is_last) begin
			ph_d    = PH_HDR;
			cnt_d   = '0;
			skip_d  = '0;
			type_d  = '0;
			field_d = '0;
			lp_d    = '0;
			done_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HDR;
			cnt_q   <= '0;
			skip_q  <= '0;
			type_q  <= '0;
			field_q <= '0;
			lp_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
			skip_q  <= skip_d;
			type_q  <= type_d;
			field_q <= field_d;
			lp_q    <= lp_d;
			done_q  <= done_d;
		end
	end

	// output register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (res_valid)
				skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= res_valid;
		end else begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (res_valid) begin
				skid_ofs_q   <= res_ofs;
				skid_found_q <= res_found;
			end
		end else if (skid_valid_q) begin
			out_ofs_q   <= skid_ofs_q;
			out_found_q <= skid_found_q;
			if (res_valid) begin
				skid_ofs_q   <= res_ofs;
				skid_found_q <= res_found;
			end
		end else if (res_valid) begin
			out_ofs_q   <= res_ofs;
			out_found_q <= res_found;
		end
	end

	assign out_valid  = out_valid_q;
	assign end_offset = out_ofs_q;
	assign found      = out_found_q;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid stage filled without an output stall");

	a_marker_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !done_q && hit && !is_last) |=> done_q)
		else $error("end marker did not stop the walk");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_last) |=> (!done_q && cnt_q == '0 && ph_q == PH_HDR))
		else $error("last byte did not clear the walker");

	a_done_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !(take && is_last)) |-> !res_valid)
		else $error("result produced after the end marker");
`endif

endmodule
